### hdl/pbfs_pkg.sv
`default_nettype none

package pbfs_pkg;

    // default width of the length-delimited byte counter
    localparam int LENGTH_COUNTER_BITS = 32;

    // result queue depth, room for two results per byte plus drain slack
    localparam int QUEUE_DEPTH = 4;

    // longest varint in bytes
    localparam int VARINT_MAX_BYTES = 10;

    // result kinds
    localparam logic [1:0] KIND_VARINT  = 2'd0;
    localparam logic [1:0] KIND_LENGTH  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    // message end status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TOO_LONG  = 2'd1;
    localparam logic [1:0] STATUS_BAD_WIRE  = 2'd2;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

    // wire types
    localparam logic [2:0] WIRE_VARINT  = 3'd0;
    localparam logic [2:0] WIRE_FIXED64 = 3'd1;
    localparam logic [2:0] WIRE_LENGTH  = 3'd2;
    localparam logic [2:0] WIRE_FIXED32 = 3'd5;

    // one result item as held in the queue
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] field_number;
        logic [2:0]  wire_kind;
        logic [63:0] field_value;
        logic [7:0]  payload_data;
        logic [1:0]  end_status;
        logic        run_last;
    } result_t;

endpackage

`default_nettype wire

### hdl/protobuf_field_scanner.sv
// protobuf field scanner: one message byte per input transfer
// a result is valid once its byte has passed the input register into the queue
// throughput: one byte per cycle while two queue slots are free; the queue of
//   four entries takes up to two results per byte, drained one per cycle on m_ready
// reset: aresetn (synchronous, active low) clears the parser state, the
//   input register and the result queue
`default_nettype none

module protobuf_field_scanner #(
    parameter int LENGTH_COUNTER_BITS = pbfs_pkg::LENGTH_COUNTER_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_result_kind,
    output logic [31:0]      m_field_number,
    output logic [2:0]       m_wire_kind,
    output logic [63:0]      m_field_value,
    output logic [7:0]       m_payload_data,
    output logic [1:0]       m_end_status,
    output logic             m_run_last
);

    localparam int QD     = pbfs_pkg::QUEUE_DEPTH;
    localparam int PTR_W  = $clog2(QD);
    localparam int CNT_W  = $clog2(QD + 1);
    localparam int LCB    = LENGTH_COUNTER_BITS;

    typedef enum logic [2:0] {
        PH_TAG,
        PH_VALUE,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_SKIP,
        PH_ERROR
    } phase_t;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  vcnt_reg, vcnt_next;
    logic [31:0] field_reg, field_next;
    logic [2:0]  wire_reg, wire_next;
    logic [LCB-1:0] remain_reg, remain_next;
    logic [1:0]  error_reg, error_next;

    // result queue
    pbfs_pkg::result_t queue_reg [QD];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    logic        room;
    logic        process;
    logic        pop;
    logic [63:0] byte_part;
    logic [63:0] acc_taken;
    logic [3:0]  vcnt_inc;
    logic        vdone;
    logic        vlong;
    logic [LCB-1:0] remain_dec;
    logic        oversize;
    logic        field_valid;
    pbfs_pkg::result_t field_res, end_res, push0, push1;
    logic [1:0]  push_n;
    phase_t      phase_mid;
    logic [1:0]  error_mid;
    logic [3:0]  vcnt_mid;

    // queue needs two free slots before a byte is processed
    assign room    = (count_reg <= CNT_W'(QD - 2));
    assign process = in_valid_reg && room;
    assign s_ready = !in_valid_reg || room;
    assign pop     = m_valid && m_ready;

    // varint byte placement, a tenth byte keeps only bit 63
    always_comb begin
        byte_part = 64'd0;
        for (int i = 0; i < pbfs_pkg::VARINT_MAX_BYTES; i++) begin
            if (vcnt_reg == 4'(i)) begin
                byte_part = {57'd0, in_data_reg[6:0]} << (7 * i);
            end
        end
    end

    assign acc_taken  = acc_reg | byte_part;
    assign vcnt_inc   = vcnt_reg + 4'd1;
    assign vdone      = !in_data_reg[7];
    assign vlong      = in_data_reg[7] && (vcnt_inc >= 4'(pbfs_pkg::VARINT_MAX_BYTES));
    assign remain_dec = remain_reg - LCB'(1);
    assign oversize   = |(acc_taken >> LCB);

    // field parsing for the byte in the input register
    always_comb begin
        phase_mid   = phase_reg;
        acc_next    = acc_reg;
        vcnt_mid    = vcnt_reg;
        field_next  = field_reg;
        wire_next   = wire_reg;
        remain_next = remain_reg;
        error_mid   = error_reg;
        field_valid = 1'b0;
        field_res   = '0;
        field_res.field_number = field_reg;
        field_res.wire_kind    = wire_reg;

        unique case (phase_reg) inside
            PH_TAG: begin
                acc_next = acc_taken;
                vcnt_mid = vcnt_inc;
                if (vlong) begin
                    error_mid = pbfs_pkg::STATUS_TOO_LONG;
                    phase_mid = PH_ERROR;
                end else if (vdone) begin
                    field_next = acc_taken[34:3];
                    wire_next  = acc_taken[2:0];
                    acc_next   = 64'd0;
                    vcnt_mid   = 4'd0;
                    unique case (acc_taken[2:0])
                        pbfs_pkg::WIRE_VARINT: phase_mid = PH_VALUE;
                        pbfs_pkg::WIRE_LENGTH: phase_mid = PH_LENGTH;
                        pbfs_pkg::WIRE_FIXED64: begin
                            phase_mid   = PH_SKIP;
                            remain_next = LCB'(8);
                        end
                        pbfs_pkg::WIRE_FIXED32: begin
                            phase_mid   = PH_SKIP;
                            remain_next = LCB'(4);
                        end
                        default: begin
                            error_mid = pbfs_pkg::STATUS_BAD_WIRE;
                            phase_mid = PH_ERROR;
                        end
                    endcase
                end
            end
            PH_VALUE, PH_LENGTH: begin
                acc_next = acc_taken;
                vcnt_mid = vcnt_inc;
                if (vlong) begin
                    error_mid = pbfs_pkg::STATUS_TOO_LONG;
                    phase_mid = PH_ERROR;
                end else if (vdone) begin
                    acc_next = 64'd0;
                    vcnt_mid = 4'd0;
                    field_res.field_value = acc_taken;
                    if (phase_reg == PH_VALUE) begin
                        field_valid           = 1'b1;
                        field_res.result_kind = pbfs_pkg::KIND_VARINT;
                        phase_mid             = PH_TAG;
                    end else if (oversize) begin
                        error_mid = pbfs_pkg::STATUS_TRUNCATED;
                        phase_mid = PH_ERROR;
                    end else begin
                        field_valid           = 1'b1;
                        field_res.result_kind = pbfs_pkg::KIND_LENGTH;
                        remain_next           = acc_taken[LCB-1:0];
                        phase_mid = (acc_taken == 64'd0) ? PH_TAG : PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                field_valid            = 1'b1;
                field_res.result_kind  = pbfs_pkg::KIND_PAYLOAD;
                field_res.payload_data = in_data_reg;
                remain_next            = remain_dec;
                if (remain_dec == '0) begin
                    phase_mid = PH_TAG;
                end
            end
            PH_SKIP: begin
                remain_next = remain_dec;
                if (remain_dec == '0) begin
                    phase_mid = PH_TAG;
                end
            end
            default: begin
                phase_mid = PH_ERROR;
            end
        endcase

        // message end result and status
        end_res             = '0;
        end_res.result_kind = pbfs_pkg::KIND_END;
        end_res.run_last    = 1'b1;
        if (error_mid != pbfs_pkg::STATUS_OK) begin
            end_res.end_status = error_mid;
        end else if (phase_mid != PH_TAG || vcnt_mid != 4'd0) begin
            end_res.end_status = pbfs_pkg::STATUS_TRUNCATED;
        end else begin
            end_res.end_status = pbfs_pkg::STATUS_OK;
        end

        field_res.run_last = !in_last_reg;

        // last byte returns the parser to its reset state
        phase_next = phase_mid;
        error_next = error_mid;
        vcnt_next  = vcnt_mid;
        if (in_last_reg) begin
            phase_next  = PH_TAG;
            acc_next    = 64'd0;
            vcnt_next   = 4'd0;
            field_next  = 32'd0;
            wire_next   = 3'd0;
            remain_next = '0;
            error_next  = pbfs_pkg::STATUS_OK;
        end

        // order of results pushed into the queue
        push0  = field_valid ? field_res : end_res;
        push1  = end_res;
        push_n = 2'(field_valid) + 2'(in_last_reg);
    end

    // input register, parser state and result queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_TAG;
            acc_reg      <= 64'd0;
            vcnt_reg     <= 4'd0;
            field_reg    <= 32'd0;
            wire_reg     <= 3'd0;
            remain_reg   <= '0;
            error_reg    <= pbfs_pkg::STATUS_OK;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end else begin
            // input transfer
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
                in_data_reg  <= s_data_byte;
                in_last_reg  <= s_last_byte;
            end else if (process) begin
                in_valid_reg <= 1'b0;
            end

            // parser state update
            if (process) begin
                phase_reg  <= phase_next;
                acc_reg    <= acc_next;
                vcnt_reg   <= vcnt_next;
                field_reg  <= field_next;
                wire_reg   <= wire_next;
                remain_reg <= remain_next;
                error_reg  <= error_next;
            end

            // queue writes
            if (process && push_n != 2'd0) begin
                queue_reg[wr_ptr_reg] <= push0;
                if (push_n == 2'd2) begin
                    queue_reg[wr_ptr_reg + PTR_W'(1)] <= push1;
                end
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(process ? push_n : 2'd0) - CNT_W'(pop);
        end
    end

    // result channel from the queue head
    assign m_valid        = (count_reg != '0);
    assign m_result_kind  = queue_reg[rd_ptr_reg].result_kind;
    assign m_field_number = queue_reg[rd_ptr_reg].field_number;
    assign m_wire_kind    = queue_reg[rd_ptr_reg].wire_kind;
    assign m_field_value  = queue_reg[rd_ptr_reg].field_value;
    assign m_payload_data = queue_reg[rd_ptr_reg].payload_data;
    assign m_end_status   = queue_reg[rd_ptr_reg].end_status;
    assign m_run_last     = queue_reg[rd_ptr_reg].run_last;

    // queue never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QD))
        else $error("result queue overflow");

    // a processed last byte leaves the parser clean
    assert property (@(posedge aclk) disable iff (!aresetn)
        process && in_last_reg |=> phase_reg == PH_TAG
            && error_reg == pbfs_pkg::STATUS_OK && vcnt_reg == 4'd0)
        else $error("parser not reset after last byte");

    // an error code is held only in the error phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        error_reg != pbfs_pkg::STATUS_OK |-> phase_reg == PH_ERROR)
        else $error("error code outside error phase");

    // varint byte count stays within the longest varint
    assert property (@(posedge aclk) disable iff (!aresetn)
        vcnt_reg <= 4'(pbfs_pkg::VARINT_MAX_BYTES))
        else $error("varint byte count out of range");

endmodule

`default_nettype wire

### dv/tb_protobuf_field_scanner.sv
`timescale 1ns / 100ps

module tb_protobuf_field_scanner;

    // cycles with no transfer on either channel before the run is abandoned
    localparam int STALL_LIMIT = 4000;
    // largest length that the byte counter can hold
    localparam bit [63:0] COUNT_LIMIT =
        64'hFFFF_FFFF_FFFF_FFFF >> (64 - pbfs_pkg::LENGTH_COUNTER_BITS);
    // wire types the scanner rejects
    localparam bit [2:0] BAD_WIRES [4] = '{3'd3, 3'd4, 3'd6, 3'd7};
    localparam int BYTES_PER_PHASE = 412;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_result_kind;
    logic [31:0] m_field_number;
    logic [2:0]  m_wire_kind;
    logic [63:0] m_field_value;
    logic [7:0]  m_payload_data;
    logic [1:0]  m_end_status;
    logic        m_run_last;

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int bytes_sent = 0;
    int messages_sent = 0;
    bit [7:0] msg_bytes[$];

    // tracks the decoder state and the fields each byte should produce
    class wire_format_scoreboard;
        typedef enum {ST_TAG, ST_VALUE, ST_LENGTH, ST_PAYLOAD, ST_SKIP, ST_ERROR} scan_state_t;
        typedef enum {VI_MORE, VI_DONE, VI_TOO_LONG} varint_step_t;

        scan_state_t       state;
        bit [63:0]         acc;
        int                vcount;
        bit [31:0]         cur_field;
        bit [2:0]          cur_wire;
        bit [63:0]         remaining;
        bit [1:0]          err;
        pbfs_pkg::result_t pending[$];
        int                errors;
        int                checked;
        int                end_count[4];

        function new();
            reset_state();
        endfunction

        function void reset_state();
            state = ST_TAG;
            acc = '0;
            vcount = 0;
            cur_field = '0;
            cur_wire = '0;
            remaining = '0;
            err = pbfs_pkg::STATUS_OK;
        endfunction

        function void enter_error(bit [1:0] code);
            err = code;
            state = ST_ERROR;
        endfunction

        // the tenth byte keeps only its bit 0, bytes past the tenth add nothing
        function varint_step_t take_varint(bit [7:0] b);
            if (vcount < pbfs_pkg::VARINT_MAX_BYTES)
                acc |= 64'(b[6:0]) << (7 * vcount);
            vcount++;
            if (!b[7])
                return VI_DONE;
            if (vcount >= pbfs_pkg::VARINT_MAX_BYTES)
                return VI_TOO_LONG;
            return VI_MORE;
        endfunction

        function void add_expected(bit [1:0] kind, bit [31:0] fld, bit [2:0] wt,
                                   bit [63:0] value, bit [7:0] data, bit [1:0] status);
            pbfs_pkg::result_t r;
            r.result_kind = kind;
            r.field_number = fld;
            r.wire_kind = wt;
            r.field_value = value;
            r.payload_data = data;
            r.end_status = status;
            r.run_last = 1'b0;
            pending.push_back(r);
        endfunction

        // advance the decoder by one accepted byte
        function void note_byte(bit [7:0] b, bit last);
            int           queued_before;
            varint_step_t step;
            bit [63:0]    v;
            bit [1:0]     status;
            queued_before = pending.size();
            case (state) inside
                ST_TAG: begin
                    step = take_varint(b);
                    if (step == VI_TOO_LONG) begin
                        enter_error(pbfs_pkg::STATUS_TOO_LONG);
                    end else if (step == VI_DONE) begin
                        cur_field = acc[34:3];
                        cur_wire = acc[2:0];
                        acc = '0;
                        vcount = 0;
                        case (cur_wire)
                            pbfs_pkg::WIRE_VARINT: state = ST_VALUE;
                            pbfs_pkg::WIRE_LENGTH: state = ST_LENGTH;
                            pbfs_pkg::WIRE_FIXED64: begin
                                state = ST_SKIP;
                                remaining = 64'd8;
                            end
                            pbfs_pkg::WIRE_FIXED32: begin
                                state = ST_SKIP;
                                remaining = 64'd4;
                            end
                            default: enter_error(pbfs_pkg::STATUS_BAD_WIRE);
                        endcase
                    end
                end
                ST_VALUE, ST_LENGTH: begin
                    step = take_varint(b);
                    if (step == VI_TOO_LONG) begin
                        enter_error(pbfs_pkg::STATUS_TOO_LONG);
                    end else if (step == VI_DONE) begin
                        v = acc;
                        acc = '0;
                        vcount = 0;
                        if (state == ST_VALUE) begin
                            add_expected(pbfs_pkg::KIND_VARINT, cur_field, cur_wire, v, '0,
                                         pbfs_pkg::STATUS_OK);
                            state = ST_TAG;
                        end else if (v > COUNT_LIMIT) begin
                            // a length the counter cannot hold can never fit
                            enter_error(pbfs_pkg::STATUS_TRUNCATED);
                        end else begin
                            add_expected(pbfs_pkg::KIND_LENGTH, cur_field, cur_wire, v, '0,
                                         pbfs_pkg::STATUS_OK);
                            remaining = v;
                            state = (v == 0) ? ST_TAG : ST_PAYLOAD;
                        end
                    end
                end
                ST_PAYLOAD: begin
                    add_expected(pbfs_pkg::KIND_PAYLOAD, cur_field, cur_wire, '0, b,
                                 pbfs_pkg::STATUS_OK);
                    remaining = (remaining - 1) & COUNT_LIMIT;
                    if (remaining == 0)
                        state = ST_TAG;
                end
                ST_SKIP: begin
                    remaining = (remaining - 1) & COUNT_LIMIT;
                    if (remaining == 0)
                        state = ST_TAG;
                end
                default: state = ST_ERROR;
            endcase

            // message end reports the first error, else whether a field was cut off
            if (last) begin
                if (err != pbfs_pkg::STATUS_OK)
                    status = err;
                else if (state != ST_TAG || vcount != 0)
                    status = pbfs_pkg::STATUS_TRUNCATED;
                else
                    status = pbfs_pkg::STATUS_OK;
                add_expected(pbfs_pkg::KIND_END, '0, '0, '0, '0, status);
                end_count[status]++;
                reset_state();
            end

            if (pending.size() > queued_before)
                pending[pending.size() - 1].run_last = 1'b1;
        endfunction

        function bit differs(string name, logic [63:0] want, logic [63:0] got);
            if (got === want)
                return 1'b0;
            $display("%0t: mismatch on %s, expected %0h, got %0h", $time, name, want, got);
            return 1'b1;
        endfunction

        // compare one result transfer against the oldest expectation
        function void check_result(pbfs_pkg::result_t got);
            pbfs_pkg::result_t want;
            bit                bad;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got kind %0d field %0h value %0h",
                         $time, got.result_kind, got.field_number, got.field_value);
                return;
            end
            want = pending.pop_front();
            bad = 1'b0;
            bad |= differs("result_kind", want.result_kind, got.result_kind);
            bad |= differs("field_number", want.field_number, got.field_number);
            bad |= differs("wire_kind", want.wire_kind, got.wire_kind);
            bad |= differs("field_value", want.field_value, got.field_value);
            bad |= differs("payload_data", want.payload_data, got.payload_data);
            bad |= differs("end_status", want.end_status, got.end_status);
            bad |= differs("run_last", want.run_last, got.run_last);
            if (bad)
                errors++;
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    wire_format_scoreboard sb;

    protobuf_field_scanner u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_field_number (m_field_number),
        .m_wire_kind    (m_wire_kind),
        .m_field_value  (m_field_value),
        .m_payload_data (m_payload_data),
        .m_end_status   (m_end_status),
        .m_run_last     (m_run_last)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // message building helpers
    function automatic bit [63:0] rand_bits(int width);
        bit [63:0] r;
        r = {$urandom, $urandom};
        if (width >= 64)
            return r;
        return r & ((64'd1 << width) - 1);
    endfunction

    // encode a varint, padded with redundant groups up to min_len bytes
    function automatic void put_varint(bit [63:0] v, int min_len);
        bit [7:0] b;
        for (int k = 1; k <= pbfs_pkg::VARINT_MAX_BYTES; k++) begin
            b = {1'b0, v[6:0]};
            v = v >> 7;
            if (k == pbfs_pkg::VARINT_MAX_BYTES) begin
                // tenth byte: upper bits fall outside the value
                if ($urandom_range(0, 1))
                    b[6:1] = 6'($urandom);
            end else if (v != 0 || k < min_len) begin
                b[7] = 1'b1;
            end
            msg_bytes.push_back(b);
            if (!b[7])
                break;
        end
    endfunction

    function automatic int pad_len();
        return ($urandom_range(0, 9) == 0) ?
            $urandom_range(1, pbfs_pkg::VARINT_MAX_BYTES) : 0;
    endfunction

    function automatic bit [31:0] rand_field_number();
        case ($urandom_range(0, 9))
            0: return 32'($urandom);
            1: return '1;
            2: return '0;
            default: return 32'($urandom_range(1, 15));
        endcase
    endfunction

    // tag bits above 34 are dropped by the scanner
    function automatic void put_tag(bit [31:0] fld, bit [2:0] wt);
        bit [28:0] upper;
        upper = ($urandom_range(0, 7) == 0) ? 29'(rand_bits(29)) : '0;
        put_varint({upper, fld, wt}, pad_len());
    endfunction

    function automatic void put_noise(int count);
        repeat (count) msg_bytes.push_back(8'($urandom));
    endfunction

    function automatic void put_field();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            put_tag(rand_field_number(), pbfs_pkg::WIRE_VARINT);
            put_varint(rand_bits($urandom_range(0, 64)), pad_len());
        end else if (pick < 70) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
            put_tag(rand_field_number(), pbfs_pkg::WIRE_LENGTH);
            put_varint(64'(len), pad_len());
            put_noise(len);
        end else if (pick < 85) begin
            put_tag(rand_field_number(), pbfs_pkg::WIRE_FIXED64);
            put_noise(8);
        end else begin
            put_tag(rand_field_number(), pbfs_pkg::WIRE_FIXED32);
            put_noise(4);
        end
    endfunction

    function automatic void put_fields(int count);
        repeat (count) put_field();
    endfunction

    // mostly well-formed messages, the rest cut short or broken
    function automatic void build_message();
        int        shape;
        int        cut;
        bit [63:0] v;
        shape = $urandom_range(0, 99);
        if (shape < 65) begin
            put_fields($urandom_range(1, 5));
        end else if (shape < 77) begin
            put_fields($urandom_range(1, 4));
            cut = $urandom_range(1, msg_bytes.size() - 1);
            while (msg_bytes.size() > cut)
                void'(msg_bytes.pop_back());
        end else if (shape < 83) begin
            put_fields($urandom_range(0, 3));
            put_tag(rand_field_number(), BAD_WIRES[$urandom_range(0, 3)]);
            put_noise($urandom_range(0, 4));
        end else if (shape < 89) begin
            // continuation bit still set on the tenth byte
            put_fields($urandom_range(0, 3));
            if ($urandom_range(0, 1))
                put_tag(rand_field_number(),
                        $urandom_range(0, 1) ? pbfs_pkg::WIRE_VARINT : pbfs_pkg::WIRE_LENGTH);
            repeat ($urandom_range(pbfs_pkg::VARINT_MAX_BYTES, pbfs_pkg::VARINT_MAX_BYTES + 2))
                msg_bytes.push_back(8'h80 | 8'($urandom));
            put_noise($urandom_range(0, 4));
        end else if (shape < 95) begin
            put_fields($urandom_range(0, 3));
            put_tag(rand_field_number(), pbfs_pkg::WIRE_LENGTH);
            v = rand_bits(64);
            if (v <= COUNT_LIMIT)
                v[$urandom_range(pbfs_pkg::LENGTH_COUNTER_BITS, 63)] = 1'b1;
            put_varint(v, pad_len());
            put_noise($urandom_range(0, 4));
        end else begin
            put_noise($urandom_range(1, 12));
        end
    endfunction

    // one byte transfer, with random idle cycles ahead of it
    task automatic send_byte(input bit [7:0] data, input bit last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= data;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_byte(data, last);
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        bytes_sent += msg_bytes.size();
        messages_sent++;
        msg_bytes.delete();
    endtask

    // result side: sample transfers and drive ready
    initial begin
        pbfs_pkg::result_t got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.result_kind = m_result_kind;
                got.field_number = m_field_number;
                got.wire_kind = m_wire_kind;
                got.field_value = m_field_value;
                got.payload_data = m_payload_data;
                got.end_status = m_end_status;
                got.run_last = m_run_last;
                sb.check_result(got);
            end
            m_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // watchdog on transfer activity
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, sb.outstanding());
        $display("TB_ERROR");
        $finish;
    end

    // stimulus
    initial begin
        int src_pct [4];
        int snk_pct [4];
        int target;
        src_pct = '{0, 82, 0, 9};
        snk_pct = '{0, 0, 82, 9};
        sb = new();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed messages: small varint, zero and short lengths, fixed32 skip,
        // bad wire type on the last byte, tag ending on the last byte,
        // largest field number, length too big for the counter
        msg_bytes = '{8'h08, 8'h00};
        send_message();
        msg_bytes = '{8'h1A, 8'h00, 8'h12, 8'h02, 8'h00, 8'hFF};
        send_message();
        msg_bytes = '{8'h0D, 8'h11, 8'h22, 8'h33, 8'h44};
        send_message();
        msg_bytes = '{8'h0F};
        send_message();
        msg_bytes = '{8'h12};
        send_message();
        msg_bytes = '{8'hF8, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00};
        send_message();
        msg_bytes = '{8'h0A, 8'h80, 8'h80, 8'h80, 8'h80, 8'h10};
        send_message();

        // random messages under each idle pattern
        for (int p = 0; p < 4; p++) begin
            src_idle_pct = src_pct[p];
            snk_stall_pct = snk_pct[p];
            target = bytes_sent + BYTES_PER_PHASE;
            while (bytes_sent < target) begin
                build_message();
                send_message();
            end
        end
        s_valid <= 1'b0;
        s_last_byte <= 1'b0;

        // drain, then allow for any stray late result
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("sent %0d bytes in %0d messages, checked %0d results",
                 bytes_sent, messages_sent, sb.checked);
        $display("message ends: ok %0d, varint too long %0d, bad wire type %0d, truncated %0d",
                 sb.end_count[pbfs_pkg::STATUS_OK], sb.end_count[pbfs_pkg::STATUS_TOO_LONG],
                 sb.end_count[pbfs_pkg::STATUS_BAD_WIRE],
                 sb.end_count[pbfs_pkg::STATUS_TRUNCATED]);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d failures, %0d results never seen", sb.errors, sb.outstanding());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### protobuf_field_scanner.f
hdl/pbfs_pkg.sv
hdl/protobuf_field_scanner.sv
dv/tb_protobuf_field_scanner.sv
